>>> design/bsai_pkg.sv
// Package for the byte-serial accumulator interpreter.
// Types, constants and opcode helpers; no dependencies.
package bsai_pkg;

  localparam int MemDepth = 256;
  localparam int AccWidth = 16;
  localparam int MemAw = $clog2(MemDepth);

  typedef enum logic [1:0] {
    OP_EXEC   = 2'd0,
    OP_IGNORE = 2'd1,
    OP_MWRITE = 2'd2,
    OP_MREAD  = 2'd3
  } operation_t;

  typedef enum logic [2:0] {
    ST_MORE    = 3'd0,
    ST_DONE    = 3'd1,
    ST_SYSCALL = 3'd2,
    ST_DIVZERO = 3'd3,
    ST_MEMDONE = 3'd4
  } status_t;

  typedef enum logic [7:0] {
    OPC_LOAD  = 8'd1,
    OPC_STORE = 8'd2,
    OPC_AND   = 8'd3,
    OPC_OR    = 8'd4,
    OPC_NOT   = 8'd5,
    OPC_XOR   = 8'd6,
    OPC_ADD   = 8'd7,
    OPC_SUB   = 8'd8,
    OPC_MUL   = 8'd9,
    OPC_DIV   = 8'd10,
    OPC_MOD   = 8'd11,
    OPC_EQ    = 8'd12,
    OPC_GT    = 8'd13,
    OPC_LT    = 8'd14,
    OPC_GE    = 8'd15,
    OPC_LE    = 8'd16,
    OPC_JMP   = 8'd17,
    OPC_JT    = 8'd18,
    OPC_JF    = 8'd19,
    OPC_LDI   = 8'd20
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ARG1, S_ARG2, S_IND, S_EXEC, S_DIV, S_DIVFIX, S_STORE, S_RESP, S_WAIT
  } state_t;

  typedef struct packed {
    logic [2:0]        status;
    logic signed [7:0] syscall_code;
    logic signed [7:0] syscall_arg_first;
    logic signed [7:0] syscall_arg_second;
    logic signed [7:0] read_data;
    logic              read_last_out;
    logic signed [15:0] accumulator_value;
    logic              condition_flag;
  } result_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic signed [7:0] data_byte;
    logic [7:0]        mem_address;
    logic              read_last;
  } request_t;

  function automatic logic [1:0] arg_count(input logic [7:0] b);
    logic signed [7:0] v;
    v = b;
    if (v == 0 || v == 5 || v == -1) return 2'd0;
    if ((v >= 1 && v <= 20) || v == -3 || v == -4) return 2'd1;
    if (v == -2 || v == -5 || v == -6 || v == -7 || v == -10) return 2'd2;
    return 2'd0;
  endfunction

endpackage

>>> design/bsai_stream_if.sv
// Valid/ready channel carrying one payload of type T.
// Payload type is set by parameter T; no package dependency.
interface bsai_stream_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/byte_serial_accumulator_interpreter.sv
// Byte-serial accumulator interpreter top level.
// Path: S_WAIT (registered memory read), S_ARG1, S_RESP; full instructions add S_EXEC,
// two-argument ones S_ARG2 and S_IND, indirect load S_STORE and S_DIVFIX; div/mod
// add the shared restoring divider (16 steps, one quotient bit per cycle), S_DIVFIX.
// One request in flight; the next is taken only after the result has been accepted.
// Reset (rst, synchronous): accumulator, flag and gathering state cleared;
// data memory is not cleared.
module byte_serial_accumulator_interpreter
  import bsai_pkg::*;
(
  input logic clk,
  input logic rst,
  bsai_stream_if.sink   in_ch,
  bsai_stream_if.source out_ch
);

  logic [7:0] mem [MemDepth];
  logic [7:0] mem_q;
  logic [MemAw-1:0] rd_addr;
  logic mem_we;
  logic [MemAw-1:0] wr_addr;
  logic [7:0] wr_data;

  state_t state, state_next;
  request_t req;
  logic signed [AccWidth-1:0] acc;
  logic cond, skipping;
  logic [7:0] ib0, ib1, ib2;
  logic [7:0] byte_index, bytes_expected;
  logic signed [7:0] x, y;
  logic [7:0] opc_len;
  logic [2:0] st;
  result_t res;
  logic res_valid;

  // divider
  logic [AccWidth-1:0] rem, quo, dvd;
  logic [7:0] dvs;
  logic [$clog2(AccWidth+1)-1:0] dcnt;
  logic [AccWidth:0] trial;
  logic neg_q, neg_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    mem_q <= mem[rd_addr];
  end

  assign in_ch.ready = (state == S_IDLE) && !res_valid;
  assign out_ch.valid = res_valid;
  assign out_ch.data = res;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_ch.valid && in_ch.ready) state_next = S_WAIT;
      default: state_next = state;
    endcase
  end

  assign trial = {rem[AccWidth-2:0], dvd[AccWidth-1]} - {{(AccWidth-7){1'b0}}, dvs};

  function automatic logic signed [7:0] res_arg(input logic [7:0] b, input logic [7:0] m);
    return b[7] ? m : b;
  endfunction

  always_ff @(posedge clk) begin
    mem_we <= 1'b0;
    if (out_ch.valid && out_ch.ready) res_valid <= 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          req <= in_ch.data;
          rd_addr <= (in_ch.data.operation == OP_MREAD) ? in_ch.data.mem_address[MemAw-1:0]
                     : MemAw'(in_ch.data.data_byte[6:0]);
          state <= S_WAIT;
        end
      end
      S_WAIT: state <= S_ARG1;   // registered read of rd_addr lands in mem_q
      S_ARG1: begin
        // memory read of mem_address or of the new byte's address settles now
        res <= '0;
        st <= ST_MORE;
        state <= S_RESP;
        unique case (operation_t'(req.operation))
          OP_MWRITE: begin
            mem_we <= 1'b1; wr_addr <= req.mem_address[MemAw-1:0];
            wr_data <= req.data_byte; st <= ST_MEMDONE;
          end
          OP_MREAD: begin
            st <= ST_MEMDONE;
            res.read_data <= mem_q; res.read_last_out <= req.read_last;
          end
          default: begin
            if (skipping) begin
              bytes_expected <= bytes_expected - 8'd1;
              if (bytes_expected == 8'd1) begin
                skipping <= 1'b0; byte_index <= '0; st <= ST_DONE;
              end
            end else begin
              if (byte_index == 0) begin
                ib0 <= req.data_byte; opc_len <= {6'd0, arg_count(req.data_byte)};
                bytes_expected <= {6'd0, arg_count(req.data_byte)};
                byte_index <= 8'd1;
                if (arg_count(req.data_byte) == 2'd0) state <= S_EXEC;
              end else begin
                if (byte_index == 8'd1) ib1 <= req.data_byte; else ib2 <= req.data_byte;
                byte_index <= byte_index + 8'd1;
                if (byte_index >= bytes_expected) begin
                  if (byte_index == 8'd1) begin
                    x <= res_arg(req.data_byte, mem_q);
                  end else begin
                    y <= res_arg(req.data_byte, mem_q);
                    rd_addr <= MemAw'(ib1[6:0]);
                  end
                  state <= (byte_index == 8'd1) ? S_EXEC : S_ARG2;
                end
              end
            end
          end
        endcase
      end
      S_ARG2: state <= S_IND;   // wait for first arg's memory byte
      S_IND: begin
        x <= res_arg(ib1, mem_q);
        state <= S_EXEC;
      end
      S_EXEC: begin
        byte_index <= '0; bytes_expected <= '0; st <= ST_DONE; state <= S_RESP;
        if ($signed(ib0) < 0) begin
          st <= ST_SYSCALL;
          res.syscall_code <= ib0;
          if (opc_len >= 8'd1) res.syscall_arg_first <= x;
          if (opc_len >= 8'd2) res.syscall_arg_second <= y;
        end else if (req.operation == OP_EXEC) begin
          unique case (ib0)
            OPC_LOAD: acc <= AccWidth'(x);
            OPC_LDI: begin rd_addr <= MemAw'(x); dcnt <= '0; state <= S_STORE; end
            OPC_STORE: begin
              mem_we <= 1'b1; wr_addr <= MemAw'(x); wr_data <= acc[7:0];
            end
            OPC_AND: acc <= acc & AccWidth'(x);
            OPC_OR:  acc <= acc | AccWidth'(x);
            OPC_NOT: acc <= ~acc;
            OPC_XOR: acc <= acc ^ AccWidth'(x);
            OPC_ADD: acc <= acc + AccWidth'(x);
            OPC_SUB: acc <= acc - AccWidth'(x);
            OPC_MUL: acc <= AccWidth'(acc * AccWidth'(x));
            OPC_DIV, OPC_MOD: begin
              if (x == 0) st <= ST_DIVZERO;
              else begin
                dvd <= acc[AccWidth-1] ? AccWidth'(-acc) : acc;
                dvs <= x[7] ? 8'(-x) : x;
                rem <= '0; dcnt <= '0;
                neg_q <= acc[AccWidth-1] ^ x[7]; neg_r <= acc[AccWidth-1];
                state <= S_DIV;
              end
            end
            OPC_EQ: cond <= acc == AccWidth'(x);
            OPC_GT: cond <= acc > AccWidth'(x);
            OPC_LT: cond <= acc < AccWidth'(x);
            OPC_GE: cond <= acc >= AccWidth'(x);
            OPC_LE: cond <= acc <= AccWidth'(x);
            OPC_JMP, OPC_JT, OPC_JF: begin
              if (ib0 == OPC_JMP || (ib0 == OPC_JT && cond) || (ib0 == OPC_JF && !cond)) begin
                skipping <= 1'b1; byte_index <= 8'd1;
                bytes_expected <= (x == 0) ? 8'd1 : x;
                st <= ST_MORE;
              end
            end
            default: ;
          endcase
        end
      end
      S_STORE: begin
        // with dcnt zero, wait for the pointer byte to reach mem_q
        if (dcnt == '0) dcnt <= dcnt + 1'b1;
        else begin
          rd_addr <= MemAw'(mem_q); dcnt <= dcnt + 1'b1; state <= S_DIVFIX;
        end
      end
      S_DIV: begin
        if (trial[AccWidth]) rem <= {rem[AccWidth-2:0], dvd[AccWidth-1]};
        else rem <= trial[AccWidth-1:0];
        quo <= {quo[AccWidth-2:0], ~trial[AccWidth]};
        dvd <= {dvd[AccWidth-2:0], 1'b0};
        dcnt <= dcnt + 1'b1;
        if (dcnt == AccWidth-1) begin dcnt <= '0; state <= S_DIVFIX; end
      end
      S_DIVFIX: begin
        state <= S_RESP;
        if (dcnt != 0) begin
          if (dcnt == 1) acc <= AccWidth'($signed(mem_q));
          else begin dcnt <= dcnt - 1'b1; state <= S_DIVFIX; end
        end else if (ib0 == OPC_DIV) acc <= neg_q ? AccWidth'(-quo) : quo;
        else acc <= neg_r ? AccWidth'(-rem) : rem;
      end
      S_RESP: begin
        res.status <= st;
        res.accumulator_value <= acc;
        res.condition_flag <= cond;
        res_valid <= 1'b1;
        state <= S_IDLE;
      end
      default: state <= S_IDLE;
    endcase
    if (rst) begin
      state <= S_IDLE; res_valid <= 1'b0; acc <= '0; cond <= 1'b0; skipping <= 1'b0;
      byte_index <= '0; bytes_expected <= '0; ib0 <= '0; ib1 <= '0; ib2 <= '0;
    end
  end

  logic unused;
  assign unused = ^{state_next, ib2};

endmodule

>>> design/bsai_checker.sv
// Port-level checks for the interpreter.
// Depends on bsai_pkg; bound to the top level.
module bsai_checker
  import bsai_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid, in_ready, out_valid, out_ready,
  input logic [2:0] status
);
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("accepted back to back");
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("ready with result pending");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_MEMDONE) else $error("bad status");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

bind byte_serial_accumulator_interpreter bsai_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .status(out_ch.data.status)
);

>>> tb/byte_serial_accumulator_interpreter_test.sv
// Self-checking testbench for the byte-serial accumulator interpreter.
// Uses bsai_pkg and bsai_stream_if; drives requests, predicts and checks every result.
module byte_serial_accumulator_interpreter_test;
  import bsai_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;

  typedef struct {
    request_t req;
    bit       hold;
    int       phase;
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bsai_stream_if #(.T(request_t)) in_ch (clk);
  bsai_stream_if #(.T(result_t))  out_ch (clk);

  byte_serial_accumulator_interpreter uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pending_t pending[$];
  result_t  expected_results[$];
  int errors = 0, accepted = 0, checked = 0, cycles = 0;
  int tx_idle_pct = 8, rx_idle_pct = 73;
  int n_divzero = 0, n_syscall = 0, n_jumps = 0;

  // predictor state
  logic [7:0]        mem [MemDepth];
  logic signed [15:0] acc;
  logic              cond;
  logic [7:0]        ibytes [4];
  int                gather_idx, gather_len;
  bit                skipping;

  function automatic int args_of(logic [7:0] b);
    int v;
    v = $signed(b);
    if (v == 0 || v == 5 || v == -1) return 0;
    if ((v >= 1 && v <= 20) || v == -3 || v == -4) return 1;
    if (v == -2 || v == -5 || v == -6 || v == -7 || v == -10) return 2;
    return 0;
  endfunction

  function automatic int resolve_arg(logic [7:0] b);
    int r;
    if (b[7]) r = $signed(mem[{1'b0, b[6:0]}]);
    else r = b;
    return r;
  endfunction

  task automatic interpret(input request_t r, output result_t e);
    int opc, x, a, v, n;
    bit jump;
    e = '0;
    e.status = ST_MORE;
    case (operation_t'(r.operation))
      OP_MWRITE: begin
        mem[r.mem_address] = r.data_byte;
        e.status = ST_MEMDONE;
      end
      OP_MREAD: begin
        e.read_data = mem[r.mem_address];
        e.read_last_out = r.read_last;
        e.status = ST_MEMDONE;
      end
      default: begin
        if (skipping) begin
          gather_len--;
          if (gather_len == 0) begin
            skipping = 0;
            gather_idx = 0;
            e.status = ST_DONE;
          end
        end else begin
          if (gather_idx == 0) gather_len = args_of(r.data_byte);
          ibytes[gather_idx & 3] = r.data_byte;
          gather_idx++;
          if (gather_idx > gather_len) begin
            opc = $signed(ibytes[0]);
            x = resolve_arg(ibytes[1]);
            a = acc;
            v = a;
            jump = 0;
            e.status = ST_DONE;
            if (opc < 0) begin
              e.status = ST_SYSCALL;
              e.syscall_code = ibytes[0];
              if (gather_len >= 1) e.syscall_arg_first = x[7:0];
              if (gather_len >= 2) e.syscall_arg_second = 8'(resolve_arg(ibytes[2]));
              n_syscall++;
            end else if (operation_t'(r.operation) == OP_EXEC) begin
              case (ibytes[0])
                OPC_LOAD:  v = x;
                OPC_LDI:   v = $signed(mem[mem[x[7:0]]]);
                OPC_STORE: mem[x[7:0]] = acc[7:0];
                OPC_AND:   v = a & x;
                OPC_OR:    v = a | x;
                OPC_NOT:   v = ~a;
                OPC_XOR:   v = a ^ x;
                OPC_ADD:   v = a + x;
                OPC_SUB:   v = a - x;
                OPC_MUL:   v = a * x;
                OPC_DIV, OPC_MOD: begin
                  if (x == 0) begin
                    e.status = ST_DIVZERO;
                    n_divzero++;
                  end else if (ibytes[0] == OPC_DIV) v = a / x;
                  else v = a % x;
                end
                OPC_EQ: cond = (a == x);
                OPC_GT: cond = (a > x);
                OPC_LT: cond = (a < x);
                OPC_GE: cond = (a >= x);
                OPC_LE: cond = (a <= x);
                OPC_JMP: jump = 1;
                OPC_JT:  jump = cond;
                OPC_JF:  jump = !cond;
                default: ;
              endcase
              acc = v[15:0];
              if (jump) begin
                n = x[7:0];
                skipping = 1;
                gather_idx = 1;
                gather_len = (n != 0) ? n : 1;
                e.status = ST_MORE;
                n_jumps++;
              end
            end
            if (!skipping) begin
              gather_idx = 0;
              gather_len = 0;
            end
          end
        end
      end
    endcase
    e.accumulator_value = acc;
    e.condition_flag = cond;
  endtask

  // driver
  always @(posedge clk) begin
    result_t e;
    bit fire;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      fire = in_ch.valid && in_ch.ready;
      if (fire) begin
        interpret(in_ch.data, e);
        expected_results.push_back(e);
        accepted++;
      end
      if (!(in_ch.valid && !fire)) begin
        if (pending.size() == 0 || (pending[0].hold && expected_results.size() != 0)) begin
          in_ch.valid <= 1'b0;
        end else begin
          tx_idle_pct = (pending[0].phase == 0) ? 8 : (pending[0].phase == 1) ? 73 : 0;
          rx_idle_pct = (pending[0].phase == 0) ? 73 : (pending[0].phase == 1) ? 8 : 0;
          if ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
          end else begin
            in_ch.valid <= 1'b1;
            in_ch.data <= pending.pop_front().req;
          end
        end
      end
    end
  end

  task automatic compare_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    result_t e, g;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        g = out_ch.data;
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding, status %0d", g.status);
          errors++;
        end else begin
          e = expected_results.pop_front();
          checked++;
          compare_field("status", e.status, g.status);
          compare_field("syscall_code", e.syscall_code, g.syscall_code);
          compare_field("syscall_arg_first", e.syscall_arg_first, g.syscall_arg_first);
          compare_field("syscall_arg_second", e.syscall_arg_second, g.syscall_arg_second);
          compare_field("read_data", e.read_data, g.read_data);
          compare_field("read_last_out", e.read_last_out, g.read_last_out);
          compare_field("accumulator_value", e.accumulator_value, g.accumulator_value);
          compare_field("condition_flag", e.condition_flag, g.condition_flag);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("** byte_serial_accumulator_interpreter: FAILED **");
      $finish;
    end
  end

  int cur_phase = 0;
  bit next_hold = 0;

  task automatic push_req(input operation_t op, input logic [7:0] b,
                          input logic [7:0] addr = 8'd0, input logic rl = 1'b0);
    pending_t p;
    p.req.operation = op;
    p.req.data_byte = b;
    p.req.mem_address = addr;
    p.req.read_last = rl;
    p.hold = next_hold;
    p.phase = cur_phase;
    next_hold = 0;
    pending.push_back(p);
  endtask

  task automatic push_instr(input operation_t op, input logic [7:0] opc,
                            input logic [7:0] a1 = 8'd0, input logic [7:0] a2 = 8'd0);
    int n;
    n = args_of(opc);
    push_req(op, opc);
    if (n >= 1) push_req(op, a1);
    if (n >= 2) push_req(op, a2);
  endtask

  function automatic logic [7:0] rand_arg();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 8'd0;
    if (k < 5) return 8'($urandom_range(127));
    return 8'($urandom_range(255, 128));
  endfunction

  task automatic random_request();
    int k, j;
    logic [7:0] opc;
    operation_t op;
    k = $urandom_range(99);
    op = ($urandom_range(99) < 85) ? OP_EXEC : OP_IGNORE;
    if (k < 8) begin
      push_req(OP_MWRITE, 8'($urandom), 8'($urandom));
    end else if (k < 16) begin
      push_req(OP_MREAD, 8'($urandom), 8'($urandom), 1'($urandom));
    end else if (k < 24) begin
      // noise: a raw byte of any kind
      push_req(operation_t'($urandom_range(3)), 8'($urandom), 8'($urandom), 1'($urandom));
    end else if (k < 34) begin
      opc = 8'($urandom_range(19, 17));
      j = $urandom_range(9);
      push_instr(op, opc, (j == 0) ? rand_arg() : 8'($urandom_range(6)));
    end else if (k < 46) begin
      opc = 8'(-$urandom_range(10, 1));
      if ($urandom_range(3) == 0) opc = 8'($urandom_range(255, 128));
      push_instr(op, opc, rand_arg(), rand_arg());
    end else if (k < 50) begin
      opc = ($urandom_range(1)) ? 8'd0 : 8'($urandom_range(127, 21));
      push_instr(op, opc);
    end else begin
      do opc = 8'($urandom_range(20, 1)); while (opc >= 17 && opc <= 19);
      push_instr(op, opc, rand_arg());
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    acc = '0;
    cond = 1'b0;
    gather_idx = 0;
    gather_len = 0;
    skipping = 0;
    foreach (ibytes[i]) ibytes[i] = '0;

    // fill the whole data memory so no later access reads an unwritten entry
    for (int a = 0; a < MemDepth; a++) push_req(OP_MWRITE, 8'($urandom), 8'(a));
    push_req(OP_MWRITE, 8'h00, 8'd1);
    push_req(OP_MWRITE, 8'hFF, 8'd2);
    push_req(OP_MWRITE, 8'h80, 8'd3);
    push_req(OP_MWRITE, 8'h7F, 8'd255);
    push_req(OP_MREAD, 8'h00, 8'd255, 1'b1);
    push_instr(OP_EXEC, OPC_LOAD, 8'd127);
    push_instr(OP_EXEC, OPC_MUL, 8'd127);
    push_instr(OP_EXEC, OPC_MUL, 8'd127);   // wraps
    push_instr(OP_EXEC, OPC_DIV, 8'd0);     // zero divisor, immediate
    push_instr(OP_EXEC, OPC_MOD, 8'h81);    // zero divisor from memory
    push_instr(OP_EXEC, OPC_DIV, 8'h82);    // divide by -1
    push_instr(OP_EXEC, OPC_LOAD, 8'h83);   // -128 from memory
    push_instr(OP_EXEC, OPC_NOT);
    push_instr(OP_EXEC, OPC_STORE, 8'd9);
    push_instr(OP_EXEC, OPC_LDI, 8'd3);
    push_instr(OP_EXEC, OPC_GE, 8'h83);
    push_instr(OP_EXEC, OPC_JT, 8'd0);      // taken with count zero
    push_req(OP_EXEC, 8'd5);
    push_instr(OP_EXEC, OPC_JF, 8'd2);      // not taken
    push_instr(OP_EXEC, OPC_JMP, 8'd2);
    push_req(OP_IGNORE, 8'hFE);
    push_req(OP_EXEC, 8'd7);
    push_instr(OP_IGNORE, OPC_JMP, 8'd3);   // ignore mode never jumps
    push_instr(OP_EXEC, 8'hFE, 8'h83, 8'd127);
    push_instr(OP_IGNORE, 8'hFD, 8'd4);
    push_instr(OP_EXEC, 8'hFF);
    push_instr(OP_EXEC, 8'h80);
    push_instr(OP_EXEC, 8'd50);

    for (int i = 0; i < 680; i++) begin
      cur_phase = (i < 225) ? 0 : (i < 450) ? 1 : 2;
      if (i == 225 || i == 330) next_hold = 1;
      random_request();
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("%0d requests sent, %0d results checked: %0d syscalls, %0d zero divides, %0d jumps",
             accepted, checked, n_syscall, n_divzero, n_jumps);
    if (errors == 0 && expected_results.size() == 0)
      $display("** byte_serial_accumulator_interpreter: PASSED **");
    else
      $display("** byte_serial_accumulator_interpreter: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
design/bsai_pkg.sv
design/bsai_stream_if.sv
design/byte_serial_accumulator_interpreter.sv
design/bsai_checker.sv
tb/byte_serial_accumulator_interpreter_test.sv
